[src/lppl_pkg.sv]
// Shared types, constants and constant functions of the log-periodic power-law term unit.
package lppl_pkg;

	localparam int INDEX_BITS_DEF = 20;
	localparam int FRAC_STEPS = 16;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CRITICAL_TIME = 2'd0;
	localparam logic [1:0] CFG_POWER_EXPONENT = 2'd1;
	localparam logic [1:0] CFG_LOG_FREQUENCY = 2'd2;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_DOMAIN = 2'd1,
		ST_SATURATED = 2'd2
	} lppl_status_t;

	localparam logic [20:0] LN2_OVER_2PI_Q24 = 21'd1850826;
	localparam logic [14:0] SIN_A = 15'd25736;
	localparam logic [13:0] SIN_B = 14'd10512;
	localparam logic [10:0] SIN_C = 11'd1160;

	// State handed from one log cell to the next.
	typedef struct packed {
		logic        valid;
		logic        ood;
		logic [4:0]  k;
		logic [31:0] y;
		logic [15:0] frac;
	} lppl_log_t;

	// State handed from one power cell to the next.
	typedef struct packed {
		logic               valid;
		logic               ood;
		logic               sat;
		logic signed [13:0] n;
		logic [15:0]        f;
		logic [31:0]        acc;
	} lppl_pow_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > v) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// Q1.30 value of 2^(2^-step), evaluated at elaboration.
	function automatic logic [63:0] pow2_coef(input int step);
		logic [63:0] c;
		c = isqrt64(64'd1 << 61);
		for (int i = 1; i < step; i++) begin
			c = isqrt64(c << 30);
		end
		return c;
	endfunction

endpackage

[src/log_periodic_power_law_terms_unit.sv]
// Top level of the log-periodic power-law term unit.
//
// For each time index t the unit returns (tc - t)^(-alpha) as unsigned Q16.16 and
// cos(omega * ln(tc - t)) as signed Q1.14, plus a status code.
// Input channel: an index transfer happens at a rising edge with start high and busy
// low. busy never rises, so a new index can be given in every cycle.
// Result channel: done is high for exactly one cycle with magnitude, amplitude and
// status valid; the receiver cannot stall, so results are never held back.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. The user must write registers only while no index is in flight;
// the block itself does not enforce it. Throughput is one index per cycle. The
// pipeline holds two rows of sixteen cells: the log2 row squares the
// mantissa once per fraction bit, and the exp row applies one root of two per
// fraction bit, each cell with one 32-bit multiplier and a register behind it.
// The cosine path runs beside the exp row and is delayed to meet it.
// Out of domain (tc not above t) gives zero terms and status 1; saturation gives an
// all-ones magnitude and status 2. Reset clears the registers and empties the pipeline.
module log_periodic_power_law_terms_unit #(
	parameter int INDEX_BITS = lppl_pkg::INDEX_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [19:0]        time_index,
	output logic               done,
	output logic [31:0]        magnitude,
	output logic signed [15:0] amplitude,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int LATENCY = 38;
	localparam int AMP_DELAY = 11;
	localparam logic [63:0] IDX_MASK_W = (64'd1 << INDEX_BITS) - 64'd1;
	localparam logic [19:0] IDX_MASK = IDX_MASK_W[19:0];

	// Configuration registers.
	logic [31:0]        critical_time_q;
	logic signed [15:0] power_exponent_q;
	logic [19:0]        log_frequency_q;

	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			critical_time_q <= '0;
			power_exponent_q <= '0;
			log_frequency_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lppl_pkg::CFG_CRITICAL_TIME: critical_time_q <= cfg_data;
				lppl_pkg::CFG_POWER_EXPONENT: power_exponent_q <= cfg_data[15:0];
				lppl_pkg::CFG_LOG_FREQUENCY: log_frequency_q <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// Stage 1: remaining time d = tc - t in Q20.12 and the domain check.
	logic [31:0] tq;
	logic        valid_s1;
	logic        ood_s1;
	logic [31:0] d_s1;

	assign tq = {time_index & IDX_MASK, 12'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ood_s1 <= critical_time_q <= tq;
		d_s1 <= critical_time_q - tq;
	end

	// Stage 2: normalize d to a Q1.31 mantissa and its exponent.
	logic [4:0]  k_c;
	logic [4:0]  sh_c;
	lppl_pkg::lppl_log_t log_head_q;
	lppl_pkg::lppl_log_t log_chain [0:lppl_pkg::FRAC_STEPS];

	always_comb begin
		k_c = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (d_s1[i]) k_c = 5'(i);
		end
		sh_c = 5'd31 - k_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_head_q <= '0;
		end else begin
			log_head_q.valid <= valid_s1;
			log_head_q.ood <= ood_s1;
			log_head_q.k <= k_c;
			log_head_q.y <= d_s1 << sh_c;
			log_head_q.frac <= '0;
		end
	end

	assign log_chain[0] = log_head_q;

	// Row of log2 cells, one fraction bit each.
	genvar gi;
	generate
		for (gi = 1; gi <= lppl_pkg::FRAC_STEPS; gi++) begin : g_log
			lppl_log_cell #(.STEP(gi)) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.cell_in(log_chain[gi - 1]),
				.cell_out(log_chain[gi])
			);
		end
	endgenerate

	// L stage: log2 of d in real units, signed Q.16.
	logic               valid_sl;
	logic               ood_sl;
	logic signed [21:0] l_sl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sl <= 1'b0;
			ood_sl <= 1'b0;
		end else begin
			valid_sl <= log_chain[lppl_pkg::FRAC_STEPS].valid;
			ood_sl <= log_chain[lppl_pkg::FRAC_STEPS].ood;
		end
	end

	always_ff @(posedge clk) begin
		l_sl <= $signed({1'b0, log_chain[lppl_pkg::FRAC_STEPS].k,
			log_chain[lppl_pkg::FRAC_STEPS].frac}) - 22'sd786432;
	end

	// P1: exponent product -alpha*L and phase product omega*L.
	logic               valid_p1;
	logic               ood_p1;
	logic signed [39:0] prod_p1;
	logic [51:0]        xw_p1;
	logic signed [37:0] al_c;
	logic signed [42:0] wl_c;

	assign al_c = power_exponent_q * l_sl;
	assign wl_c = $signed({1'b0, log_frequency_q}) * l_sl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_p1 <= 1'b0;
			ood_p1 <= 1'b0;
		end else begin
			valid_p1 <= valid_sl;
			ood_p1 <= ood_sl;
		end
	end

	always_ff @(posedge clk) begin
		prod_p1 <= -(40'(al_c));
		xw_p1 <= 52'(wl_c);
	end

	// P2: round the exponent to Q.16, split it, and form the phase partial products.
	logic [39:0]        abs_c;
	logic [39:0]        rr_c;
	logic signed [29:0] e_c;
	logic [46:0]        lo_p2;
	logic [46:0]        hi_p2;
	lppl_pkg::lppl_pow_t pow_head_q;
	lppl_pkg::lppl_pow_t pow_chain [0:lppl_pkg::FRAC_STEPS];

	always_comb begin
		abs_c = prod_p1[39] ? 40'(-prod_p1) : 40'(prod_p1);
		rr_c = (abs_c + 40'd2048) >> 12;
		e_c = prod_p1[39] ? -$signed(rr_c[29:0]) : $signed(rr_c[29:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pow_head_q <= '0;
		end else begin
			pow_head_q.valid <= valid_p1;
			pow_head_q.ood <= ood_p1;
			pow_head_q.sat <= e_c >= 30'sd1048576;
			pow_head_q.n <= e_c[29:16];
			pow_head_q.f <= e_c[15:0];
			pow_head_q.acc <= 32'd1 << 30;
		end
	end

	assign pow_chain[0] = pow_head_q;

	always_ff @(posedge clk) begin
		lo_p2 <= xw_p1[25:0] * lppl_pkg::LN2_OVER_2PI_Q24;
		hi_p2 <= xw_p1[51:26] * lppl_pkg::LN2_OVER_2PI_Q24;
	end

	// Row of 2^f cells, one fraction bit each.
	generate
		for (gi = 1; gi <= lppl_pkg::FRAC_STEPS; gi++) begin : g_pow
			lppl_pow_cell #(.STEP(gi)) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.cell_in(pow_chain[gi - 1]),
				.cell_out(pow_chain[gi])
			);
		end
	endgenerate

	// Cosine path: phase fraction, quarter-wave fold, then the odd polynomial.
	logic [51:0] turns_c;
	logic [15:0] r_c;
	logic [14:0] z_p3;
	logic [1:0]  quad_p3;
	logic [14:0] z_p4;
	logic [1:0]  quad_p4;
	logic [14:0] z2_p4;
	logic [14:0] z_p5;
	logic [1:0]  quad_p5;
	logic [14:0] z2_p5;
	logic [13:0] inner_p5;
	logic [14:0] z_p6;
	logic [1:0]  quad_p6;
	logic [14:0] outer_p6;
	logic signed [15:0] amp_p7;
	logic [29:0] zz_c;
	logic [25:0] zc_c;
	logic [28:0] zi_c;
	logic [29:0] zo_c;
	logic [15:0] s_c;

	always_comb begin
		turns_c = 52'(lo_p2) + {hi_p2[25:0], 26'd0};
		r_c = turns_c[51:36] + 16'd16384;
		zz_c = z_p3 * z_p3;
		zc_c = z2_p4 * lppl_pkg::SIN_C;
		zi_c = z2_p5 * inner_p5;
		zo_c = z_p6 * outer_p6;
		s_c = (zo_c[29:14] > 16'd16384) ? 16'd16384 : zo_c[29:14];
	end

	always_ff @(posedge clk) begin
		quad_p3 <= r_c[15:14];
		z_p3 <= r_c[14] ? 15'd16384 - {1'b0, r_c[13:0]} : {1'b0, r_c[13:0]};
		z_p4 <= z_p3;
		quad_p4 <= quad_p3;
		z2_p4 <= zz_c[28:14];
		z_p5 <= z_p4;
		quad_p5 <= quad_p4;
		z2_p5 <= z2_p4;
		inner_p5 <= lppl_pkg::SIN_B - 14'(zc_c >> 14);
		z_p6 <= z_p5;
		quad_p6 <= quad_p5;
		outer_p6 <= lppl_pkg::SIN_A - 15'(zi_c >> 14);
		amp_p7 <= quad_p6[1] ? -$signed(s_c) : $signed(s_c);
	end

	// Delay line that lines the amplitude up with the end of the 2^f row.
	logic signed [15:0] amp_dl_q [0:AMP_DELAY - 1];

	always_ff @(posedge clk) begin
		amp_dl_q[0] <= amp_p7;
		for (int i = 1; i < AMP_DELAY; i++) begin
			amp_dl_q[i] <= amp_dl_q[i - 1];
		end
	end

	// Final stage: scale 2^f by 2^n into Q16.16 with rounding and saturation.
	lppl_pkg::lppl_pow_t last_c;
	logic signed [14:0] sh_s_c;
	logic [5:0]         shamt_c;
	logic [33:0]        scaled_c;
	logic               over_c;

	always_comb begin
		last_c = pow_chain[lppl_pkg::FRAC_STEPS];
		sh_s_c = 15'sd14 - 15'(last_c.n);
		shamt_c = sh_s_c[5:0];
		scaled_c = '0;
		if (sh_s_c <= 15'sd0) begin
			scaled_c = {2'b00, last_c.acc} << (last_c.n - 14'sd14);
		end else if (sh_s_c <= 15'sd32) begin
			scaled_c = ({2'b00, last_c.acc} + (34'd1 << (shamt_c - 6'd1))) >> shamt_c;
		end
		over_c = last_c.sat || (scaled_c > 34'h0FFFFFFFF);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= last_c.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (last_c.ood) begin
			magnitude <= '0;
			amplitude <= '0;
			status <= lppl_pkg::ST_DOMAIN;
		end else begin
			amplitude <= amp_dl_q[AMP_DELAY - 1];
			if (over_c) begin
				magnitude <= 32'hFFFFFFFF;
				status <= lppl_pkg::ST_SATURATED;
			end else begin
				magnitude <= scaled_c[31:0];
				status <= lppl_pkg::ST_OK;
			end
		end
	end

	// Every result comes from an index transferred a fixed number of cycles earlier.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching index transfer");

	// Out-of-domain results carry zero terms.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == lppl_pkg::ST_DOMAIN) |-> (magnitude == 32'd0 && amplitude == 16'sd0))
		else $error("out-of-domain result with nonzero terms");

	// A saturated result reports the largest magnitude.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == lppl_pkg::ST_SATURATED) |-> (magnitude == 32'hFFFFFFFF))
		else $error("saturated status without full-scale magnitude");

	// The amplitude never leaves the unit circle range.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (amplitude <= 16'sd16384 && amplitude >= -16'sd16384))
		else $error("amplitude out of range");

endmodule

[src/lppl_log_cell.sv]
// One cell of the log2 chain: squares the mantissa and produces one fraction bit.
module lppl_log_cell #(
	parameter int STEP = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lppl_pkg::lppl_log_t cell_in,
	output lppl_pkg::lppl_log_t cell_out
);

	logic [63:0] sq;
	lppl_pkg::lppl_log_t nxt;

	always_comb begin
		sq = cell_in.y * cell_in.y;
		nxt = cell_in;
		if (sq[63]) begin
			nxt.y = sq[63:32];
			nxt.frac[lppl_pkg::FRAC_STEPS - STEP] = 1'b1;
		end else begin
			nxt.y = sq[62:31];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_out <= '0;
		end else begin
			cell_out <= nxt;
		end
	end

endmodule

[src/lppl_pow_cell.sv]
// One cell of the 2^f chain: multiplies by a fixed root of two when its fraction bit is set.
module lppl_pow_cell #(
	parameter int STEP = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lppl_pkg::lppl_pow_t cell_in,
	output lppl_pkg::lppl_pow_t cell_out
);

	localparam logic [63:0] COEF_FULL = lppl_pkg::pow2_coef(STEP);
	localparam logic [31:0] COEF = COEF_FULL[31:0];

	logic [63:0] prod;
	logic [63:0] rounded;
	lppl_pkg::lppl_pow_t nxt;

	always_comb begin
		prod = cell_in.acc * COEF;
		rounded = (prod + (64'd1 << 29)) >> 30;
		nxt = cell_in;
		if (cell_in.f[lppl_pkg::FRAC_STEPS - STEP]) begin
			nxt.acc = rounded[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_out <= '0;
		end else begin
			cell_out <= nxt;
		end
	end

endmodule

[sim/tb_log_periodic_power_law_terms_unit.sv]
// Self-checking testbench of the log-periodic power-law term unit.
module tb_log_periodic_power_law_terms_unit;

	localparam int IDX_W = lppl_pkg::INDEX_BITS_DEF;
	// The pipeline is 38 deep, output register included; the drain wait is longer than that.
	localparam int DRAIN_CYCLES = 45;
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		logic [31:0]            magnitude;
		logic [15:0]            amplitude;
		lppl_pkg::lppl_status_t status;
	} lppl_terms_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [19:0]        time_index;
	logic               done;
	logic [31:0]        magnitude;
	logic signed [15:0] amplitude;
	logic [1:0]         status;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;

	log_periodic_power_law_terms_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.time_index(time_index),
		.done(done),
		.magnitude(magnitude),
		.amplitude(amplitude),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// The predictor keeps its own copy of the three registers.
	logic [31:0]        tc_q20_12;
	logic signed [15:0] alpha_q4_12;
	logic [19:0]        omega_q8_12;

	logic [19:0]  index_queue[$];
	lppl_terms_t  terms_queue[$];
	int           errors;
	bit           hold_sender;
	int           idle_cycles;

	always #4 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// log2 of a nonzero raw value: integer part from the top bit, then sixteen
	// fraction bits from repeated squaring of the Q1.31 mantissa.
	function automatic logic [31:0] log2_fixed(logic [31:0] d);
		int unsigned     k;
		logic [15:0]     frac;
		longint unsigned y;
		k = 31;
		frac = 0;
		while (d[k] == 1'b0) k--;
		y = longint'(d) << (31 - k);
		for (int i = 1; i <= 16; i++) begin
			y = (y * y) >> 31;
			if (y >= (64'd1 << 32)) begin
				frac[16 - i] = 1'b1;
				y = y >> 1;
			end
		end
		return (k << 16) | frac;
	endfunction

	// 2^f for a Q0.16 fraction, giving Q1.30, by one root of two per set bit.
	function automatic longint unsigned exp2_fraction(logic [15:0] f);
		longint unsigned acc;
		longint unsigned root;
		acc = 64'd1 << 30;
		root = int_sqrt(64'd1 << 61);
		for (int i = 1; i <= 16; i++) begin
			if (f[16 - i]) acc = (acc * root + (64'd1 << 29)) >> 30;
			root = int_sqrt(root << 30);
		end
		return acc;
	endfunction

	function automatic int unsigned sine_quarter(int unsigned z);
		int unsigned z2;
		int unsigned inner;
		int unsigned outer;
		int unsigned s;
		z2 = (z * z) >> 14;
		inner = lppl_pkg::SIN_B - ((z2 * lppl_pkg::SIN_C) >> 14);
		outer = lppl_pkg::SIN_A - ((z2 * inner) >> 14);
		s = (z * outer) >> 14;
		return (s > 16384) ? 16384 : s;
	endfunction

	function automatic lppl_terms_t predict_terms(logic [19:0] t_in);
		lppl_terms_t     res;
		longint unsigned tq;
		logic [31:0]     d;
		longint          lg;
		longint          prod;
		longint unsigned mag_abs;
		longint          e16;
		longint          n;
		longint          f;
		longint unsigned acc;
		longint unsigned turns;
		int unsigned     r;
		int unsigned     quad;
		int unsigned     s;
		tq = longint'(t_in & ((64'd1 << IDX_W) - 1)) << 12;
		res.magnitude = 0;
		res.amplitude = 0;
		res.status = lppl_pkg::ST_OK;
		// Out of domain: tc is not beyond t.
		if (longint'(tc_q20_12) <= tq) begin
			res.status = lppl_pkg::ST_DOMAIN;
			return res;
		end
		d = 32'(longint'(tc_q20_12) - tq);
		lg = longint'(log2_fixed(d)) - (longint'(12) << 16);

		prod = -longint'(alpha_q4_12) * lg;
		mag_abs = (prod < 0) ? -prod : prod;
		mag_abs = (mag_abs + 2048) >> 12;
		e16 = (prod < 0) ? -longint'(mag_abs) : longint'(mag_abs);
		if (e16 >= (longint'(16) << 16)) begin
			res.magnitude = 32'hFFFF_FFFF;
			res.status = lppl_pkg::ST_SATURATED;
		end else begin
			if (e16 >= 0) n = e16 / 65536;
			else n = -longint'((longint'(-e16) + 65535) >> 16);
			f = e16 - n * 65536;
			acc = exp2_fraction(16'(f));
			if (n >= 14) begin
				acc = acc << (n - 14);
			end else if (14 - n > 62) begin
				// Far below the Q16.16 resolution: the magnitude underflows to zero.
				acc = 0;
			end else begin
				acc = (acc + (64'd1 << (13 - n))) >> (14 - n);
			end
			if (acc > 64'hFFFF_FFFF) begin
				res.magnitude = 32'hFFFF_FFFF;
				res.status = lppl_pkg::ST_SATURATED;
			end else begin
				res.magnitude = 32'(acc);
			end
		end

		// The phase keeps only the fraction of a turn, so the product may wrap.
		turns = longint'(omega_q8_12) * longint'(lg) * longint'(lppl_pkg::LN2_OVER_2PI_Q24);
		turns = turns & ((64'd1 << 52) - 1);
		r = 32'((turns >> 36) + 16384) & 32'hFFFF;
		quad = r >> 14;
		r = r & 32'h3FFF;
		s = quad[0] ? sine_quarter(16384 - r) : sine_quarter(r);
		res.amplitude = quad[1] ? 16'(-int'(s)) : 16'(s);
		return res;
	endfunction

	// Sender: bursts of random length separated by random gaps. On every index
	// transfer the expected terms are computed with the registers in force.
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			time_index <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (start && !busy) terms_queue = {terms_queue, predict_terms(time_index)};
			if (start && busy) begin
				// The transfer has not happened yet; keep the item on the port.
			end else if (hold_sender || index_queue.size() == 0) begin
				start <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				time_index <= index_queue.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					// Some bursts run back to back with no gap at all.
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver: results cannot be held off, so each strobe is checked in place.
	always @(posedge clk) begin
		lppl_terms_t want;
		if (arst_n && done) begin
			if (terms_queue.size() == 0) begin
				$display("%0t: result with none expected: mag %h amp %h status %0d",
					$time, magnitude, amplitude, status);
				errors++;
			end else begin
				want = terms_queue.pop_front();
				if (magnitude !== want.magnitude) begin
					$display("%0t: magnitude expected %h actual %h",
						$time, want.magnitude, magnitude);
					errors++;
				end
				if (amplitude !== want.amplitude) begin
					$display("%0t: amplitude expected %h actual %h",
						$time, want.amplitude, amplitude);
					errors++;
				end
				if (status !== 2'(want.status)) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, status);
					errors++;
				end
			end
		end
	end

	// Watchdog: ends the run after too many cycles with no transfer of any kind.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Writes one register through the configuration channel and mirrors it in the predictor.
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			lppl_pkg::CFG_CRITICAL_TIME: tc_q20_12 = value;
			lppl_pkg::CFG_POWER_EXPONENT: alpha_q4_12 = value[15:0];
			lppl_pkg::CFG_LOG_FREQUENCY: omega_q8_12 = value[19:0];
			default: begin
				// Unused index: the write has no effect.
			end
		endcase
	endtask

	// Waits until every queued index has gone in and every result has come back,
	// then lets the pipeline settle before registers change.
	task automatic wait_drained();
		do @(posedge clk); while (index_queue.size() != 0 || start || terms_queue.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_registers(logic [31:0] tc, logic [15:0] alpha, logic [19:0] omega);
		write_reg(lppl_pkg::CFG_CRITICAL_TIME, tc);
		write_reg(lppl_pkg::CFG_POWER_EXPONENT, {16'h0, alpha});
		write_reg(lppl_pkg::CFG_LOG_FREQUENCY, {12'h0, omega});
	endtask

	// Queues random indexes, mostly inside the domain so the log and exp rows
	// get real work; a tenth range over every bit of the field.
	task automatic queue_random(int count);
		logic [31:0] top;
		top = tc_q20_12 >> 12;
		if (top > 32'hFFFFF) top = 32'hFFFFF;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0 || top == 0)
				index_queue = {index_queue, 20'($urandom)};
			else if ($urandom_range(0, 5) == 0)
				index_queue = {index_queue,
					20'(top - $urandom_range(0, (top > 8) ? 8 : top))};
			else
				index_queue = {index_queue, 20'($urandom_range(0, top))};
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_sender = 1'b0;
		tc_q20_12 = '0;
		alpha_q4_12 = '0;
		omega_q8_12 = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: tc is zero, so every index lies out of the domain.
		index_queue = '{20'd0, 20'd1, 20'hFFFFF};
		wait_drained();

		// Directed: extreme indexes, ties with tc, saturation and underflow.
		set_registers(32'h0040_0000, 16'sh1000, 20'h01000);
		index_queue = '{20'd0, 20'd1, 20'd2, 20'h3FF, 20'h400, 20'h401, 20'hFFFFF,
			20'h80000};
		wait_drained();
		set_registers(32'hFFFF_FFFF, 16'h8000, 20'hFFFFF);
		index_queue = '{20'd0, 20'd1, 20'hFFFFF, 20'h55555, 20'hAAAAA};
		wait_drained();
		set_registers(32'h0000_1001, 16'h7FFF, 20'd0);
		index_queue = '{20'd0, 20'd1};
		wait_drained();
		set_registers(32'h0000_1FFF, 16'h8000, 20'h00001);
		index_queue = '{20'd0, 20'd1, 20'd2};
		wait_drained();
		set_registers(32'hFFFF_FFFF, 16'h7FFF, 20'h12345);
		index_queue = '{20'd0, 20'hFFFFF, 20'h7FFFF};
		wait_drained();
		// A write to the unused register index must leave the others alone.
		write_reg(2'd3, 32'hFFFF_FFFF);
		index_queue = '{20'd5, 20'h00ABC};
		wait_drained();

		// Random phases, each under a fresh set of registers.
		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 3))
				0: set_registers($urandom, 16'($urandom_range(0, 8191) - 4096), 20'($urandom));
				1: set_registers($urandom_range(32'h1000, 32'h0100_0000), 16'($urandom),
					20'($urandom_range(0, 4095)));
				default: set_registers($urandom, 16'($urandom), 20'($urandom));
			endcase
			queue_random(75);
			// Once per phase the sender waits until every result is back.
			do @(posedge clk); while (index_queue.size() != 0 || start);
			hold_sender = 1'b1;
			do @(posedge clk); while (terms_queue.size() != 0);
			hold_sender = 1'b0;
			queue_random(75);
			wait_drained();
		end

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
